// ----- rtl/brfr_pkg.sv -----
// ----------------------------------------------------------------------------
// brfr_pkg
// Shared types, constants and the byte-wise CRC-16-CCITT fold for the
// bootloader reply frame receiver.
// ----------------------------------------------------------------------------
package brfr_pkg;

  localparam logic [7:0]  ACK_BYTE    = 8'h00;
  localparam logic [7:0]  HEADER_BYTE = 8'h80;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_ACK    = 2'd1;
  localparam logic [1:0] ERR_HEADER = 2'd2;
  localparam logic [1:0] ERR_CRC    = 2'd3;

  typedef struct packed {
    logic [1:0] error_code;
    logic       frame_error;
    logic       frame_done;
    logic       payload_valid;
    logic [7:0] payload_byte;
  } result_t;

  // poly 0x1021, MSB first, one byte per call
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'h0, x[7:4]};
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

// ----- rtl/bootloader_reply_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// bootloader_reply_frame_receiver
// Stream receiver for bootloader reply frames with CRC-16-CCITT check.
// ----------------------------------------------------------------------------
// Each input transaction carries one received byte, or a start flag in tuser
// that rearms the receiver. The frame is ack 0x00, header 0x80, a 16-bit
// little-endian length, the payload, then a little-endian CRC-16-CCITT
// (init 0xFFFF). Every input transaction yields exactly one output
// transaction: payload bytes are flagged in tuser, and done/error status
// with the error code (1 bad ack, 2 bad header, 3 CRC mismatch) is reported
// on every transaction once reached. Throughput is one byte per clock while the
// output is not stalled; each byte passes through the input register and the
// result register around the combinational state and CRC update.
module bootloader_reply_frame_receiver import brfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] frame_done,
                                      // [9] frame_error, [11:10] error_code
  output logic        m_axis_tuser    // [0] payload_valid
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       advance;
  result_t    result;
  result_t    out_result;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  brfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .start_req (in_start),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_axis_tdata = {4'h0, out_result.error_code, out_result.frame_error,
                         out_result.frame_done, out_result.payload_byte};
  assign m_axis_tuser = out_result.payload_valid;

endmodule

// ----- rtl/brfr_core.sv -----
// ----------------------------------------------------------------------------
// brfr_core
// Frame state, length/CRC bookkeeping and result formation for one byte.
// ----------------------------------------------------------------------------
module brfr_core import brfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic       start_req,
  output result_t    result
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ACK     = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CRC     = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_low, received_crc_low_next;
  logic [1:0]  fail_reason, fail_reason_next;
  logic [15:0] seen_inc;
  logic [15:0] len_full;

  assign seen_inc = bytes_seen + 16'd1;
  assign len_full = frame_length | {rx_byte, 8'h00};

  always_comb begin
    phase_next            = phase;
    frame_length_next     = frame_length;
    bytes_seen_next       = bytes_seen;
    running_crc_next      = running_crc;
    received_crc_low_next = received_crc_low;
    fail_reason_next      = fail_reason;
    result                = '0;
    if (start_req) begin
      phase_next            = PH_ACK;
      frame_length_next     = '0;
      bytes_seen_next       = '0;
      running_crc_next      = CRC_INIT;
      received_crc_low_next = '0;
      fail_reason_next      = ERR_NONE;
    end else begin
      unique case (phase)
        PH_ACK: begin
          if (rx_byte == ACK_BYTE) begin
            phase_next = PH_HEADER;
          end else begin
            phase_next       = PH_ERROR;
            fail_reason_next = ERR_ACK;
          end
        end
        PH_HEADER: begin
          if (rx_byte == HEADER_BYTE) begin
            phase_next      = PH_LEN;
            bytes_seen_next = '0;
          end else begin
            phase_next       = PH_ERROR;
            fail_reason_next = ERR_HEADER;
          end
        end
        PH_LEN: begin
          if (bytes_seen == 16'd0) begin
            frame_length_next = {8'h00, rx_byte};
            bytes_seen_next   = 16'd1;
          end else begin
            frame_length_next = len_full;
            bytes_seen_next   = '0;
            phase_next        = (len_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          result.payload_valid = 1'b1;
          result.payload_byte  = rx_byte;
          running_crc_next     = crc_fold(running_crc, rx_byte);
          if (seen_inc == frame_length) begin
            bytes_seen_next = '0;
            phase_next      = PH_CRC;
          end else begin
            bytes_seen_next = seen_inc;
          end
        end
        PH_CRC: begin
          if (bytes_seen == 16'd0) begin
            received_crc_low_next = rx_byte;
            bytes_seen_next       = 16'd1;
          end else begin
            bytes_seen_next = '0;
            if ({rx_byte, received_crc_low} == running_crc) begin
              phase_next       = PH_DONE;
              fail_reason_next = ERR_NONE;
            end else begin
              phase_next       = PH_ERROR;
              fail_reason_next = ERR_CRC;
            end
          end
        end
        default: begin
        end
      endcase
    end
    result.frame_done  = (phase_next == PH_DONE);
    result.frame_error = (phase_next == PH_ERROR);
    result.error_code  = fail_reason_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      frame_length     <= '0;
      bytes_seen       <= '0;
      running_crc      <= CRC_INIT;
      received_crc_low <= '0;
      fail_reason      <= ERR_NONE;
    end else if (step) begin
      phase            <= phase_next;
      frame_length     <= frame_length_next;
      bytes_seen       <= bytes_seen_next;
      running_crc      <= running_crc_next;
      received_crc_low <= received_crc_low_next;
      fail_reason      <= fail_reason_next;
    end
  end

endmodule
